/* rtl/sbbm_pkg.sv */
// shared types and constants for the spectrum bin to bar mapper
// depends on nothing; used by the front, back and top level modules
`default_nettype none
package sbbm_pkg;
  localparam int unsigned MAG_W = 8;
  localparam int unsigned SUM_W = 16;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned HGT_W = 10;
  localparam int unsigned COL_W = 24;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 1'b1;

  // one job handed from front to back: a sum to divide by a count
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [6:0]       bar;
    logic             last;
  } sbbm_job_t;

  function automatic logic [COL_W-1:0] gradient(input logic [MAG_W-1:0] m);
    logic [7:0] t;
    t = {m[5:0], 2'b00};
    unique case (m[7:6])
      2'd0: gradient = {8'h00, t, 8'hFF};
      2'd1: gradient = {8'h00, 8'hFF, 8'hFF - t};
      2'd2: gradient = {t, 8'hFF, 8'h00};
      default: gradient = {8'hFF, 8'hFF - t, 8'h00};
    endcase
  endfunction
endpackage
`default_nettype wire

/* rtl/sbbm_front.sv */
// front part: counts bins, groups or replicates them into bar jobs
// depends on sbbm_pkg; feeds the job queue in the top level
`default_nettype none
module sbbm_front #(
  parameter int unsigned BARS = 32,
  parameter int unsigned MAX_BINS = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic restart,
  input  wire logic [8:0] bin_count,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [7:0] magnitude,
  output logic      job_valid,
  input  wire logic job_ready,
  output sbbm_pkg::sbbm_job_t job
);
  import sbbm_pkg::*;
  localparam int unsigned BW = 7;
  localparam int unsigned PW = 13;

  logic [PW-1:0] n, pos;
  logic [BW-1:0] nbar;
  logic [SUM_W-1:0] gsum;
  logic [CNT_W-1:0] gcnt;
  logic busy;
  logic [MAG_W-1:0] held;
  logic [PW+BW-1:0] prod0, prod1;
  logic [PW-1:0] start0, start1;
  logic emit_small, emit_big, frame_end;

  always_comb begin
    if (bin_count == 9'd0) n = PW'(1);
    else if (32'(bin_count) > MAX_BINS) n = PW'(MAX_BINS);
    else n = PW'(bin_count);
    prod0 = (PW+BW)'(nbar) * (PW+BW)'(n);
    prod1 = (PW+BW)'(nbar + BW'(1)) * (PW+BW)'(n);
    start0 = PW'(prod0 / BARS);
    start1 = PW'(prod1 / BARS);
  end

  assign emit_small = (nbar < BW'(BARS)) && (start0 == pos);
  assign emit_big = (nbar < BW'(BARS)) && (pos + PW'(1) >= start1);
  assign frame_end = (pos + PW'(1) >= n);
  assign in_ready = !busy && !restart;
  assign job_valid = busy && (n <= PW'(BARS) ? emit_small : emit_big);

  always_comb begin
    job.bar = nbar;
    job.last = (nbar == BW'(BARS - 1));
    if (n <= PW'(BARS)) begin
      job.sum = SUM_W'(held);
      job.count = CNT_W'(1);
    end else begin
      job.sum = gsum + SUM_W'(held);
      job.count = gcnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy <= 1'b0;
      pos <= '0;
      nbar <= '0;
      gsum <= '0;
      gcnt <= '0;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        held <= magnitude;
      end
    end else if (job_valid) begin
      if (job_ready) begin
        if (n > PW'(BARS)) begin
          gsum <= '0;
          gcnt <= '0;
          busy <= 1'b0;
          if (frame_end) begin
            pos <= '0;
            nbar <= '0;
          end else begin
            pos <= pos + PW'(1);
            nbar <= nbar + BW'(1);
          end
        end else nbar <= nbar + BW'(1);
      end
    end else begin
      // no more bars from this bin
      busy <= 1'b0;
      if (frame_end) begin
        pos <= '0;
        nbar <= '0;
        gsum <= '0;
        gcnt <= '0;
      end else begin
        pos <= pos + PW'(1);
        if (n > PW'(BARS)) begin
          gsum <= gsum + SUM_W'(held);
          gcnt <= gcnt + CNT_W'(1);
        end
      end
    end
  end

  property p_job_bar_range;
    @(posedge clk) disable iff (rst) job_valid |-> (nbar < BW'(BARS));
  endproperty
  a_job_bar_range: assert property (p_job_bar_range) else $error("bar out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("accept while busy");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < n || $past(restart) || $past(rst) || $changed(bin_count))
    else $error("bin position past frame");
endmodule
`default_nettype wire

/* rtl/sbbm_back.sv */
// back part: serial divide for the mean, height scale, colour, output register
// depends on sbbm_pkg; takes jobs from the queue in the top level
`default_nettype none
module sbbm_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [9:0] display_height,
  input  wire logic job_valid,
  output logic      job_ready,
  input  wire sbbm_pkg::sbbm_job_t job,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [5:0] out_bar,
  output logic [9:0] out_height,
  output logic [23:0] out_color,
  output logic      out_last
);
  import sbbm_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_HDIV, S_OUT} state_t;
  state_t state;
  logic [SUM_W-1:0] quo;
  logic [CNT_W:0] rem;
  logic [CNT_W-1:0] den;
  logic [4:0] step;
  logic [MAG_W-1:0] avg;
  logic [17:0] prod;
  logic [9:0] hq;
  logic [9:0] maxh;
  logic [17:0] maxh_prod;
  logic [CNT_W:0] rem_sh;
  logic [6:0] bar;
  logic last;
  logic [18:0] hrem;
  logic [25:0] hest_prod;
  logic [9:0] hest;

  always_comb begin
    maxh_prod = 18'(display_height) * 18'd205;
    maxh = 10'(maxh_prod >> 8);
    // correct the reciprocal estimate of x*4/5
    if (18'(maxh) * 18'd5 > 18'(display_height) * 18'd4) maxh = maxh - 10'd1;
    if (maxh < 10'd5) maxh = 10'd5;
    rem_sh = {rem[CNT_W-1:0], quo[SUM_W-1]};
    // x*257/65536 is at most one below x/255; the remainder check fixes it
    hest_prod = 26'(prod) * 26'd257;
    hest = 10'(hest_prod >> 16);
  end

  assign job_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (job_valid) begin
          quo <= job.sum; den <= job.count; rem <= '0;
          bar <= job.bar; last <= job.last; step <= 5'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            quo <= {quo[SUM_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[SUM_W-2:0], 1'b0};
          end
          step <= step + 5'd1;
          if (step == 5'(SUM_W - 1)) state <= S_MUL;
        end
        S_MUL: begin
          avg <= quo[7:0];
          prod <= 18'(quo[7:0]) * 18'(maxh - 10'd5);
          state <= S_HDIV;
        end
        S_HDIV: begin
          hq <= hest;
          hrem <= 19'(prod - 18'(hest) * 18'd255);
          state <= S_OUT;
        end
        S_OUT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_bar <= bar[5:0];
          out_height <= hq + 10'd5 + ((hrem >= 19'd255) ? 10'd1 : 10'd0);
          out_color <= gradient(avg);
          out_last <= last;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && !(state == S_OUT)) out_valid <= 1'b0;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_height: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_height >= 10'd5) else $error("bar too short");
endmodule
`default_nettype wire

/* rtl/spectrum_bin_to_bar_mapper.sv */
// top level of the spectrum bin to bar mapper: config registers, job queue
// depends on sbbm_pkg, sbbm_front and sbbm_back
//
// channel   dir  payload
// s_axis    in   tdata[7:0] magnitude
// m_axis    out  tdata[38:0] bar_index, height, bar_color; tlast last_bar
// cfg       in   cfg_index, cfg_data
//
// front: one bin at a time; while averaging, the last bin of a group emits
// its job; when bins do not outnumber bars, a bin emits a job per bar
// back: one bar at a time (load, 16 step mean divide, multiply, height scale,
// output register); once the queue fills the front waits on the back
// reset clears frame state and the queue; a bin_count write restarts the frame
// a two entry queue lets the front stall on the back and the back on m_axis
`default_nettype none
module spectrum_bin_to_bar_mapper #(
  parameter int unsigned BARS = 32,
  parameter int unsigned MAX_BINS = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // magnitude
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [39:0] m_axis_tdata,       // bar_index, height, bar_color, pad
  output logic      m_axis_tlast,         // last_bar
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [9:0] cfg_data
);
  import sbbm_pkg::*;
  logic [8:0] bin_count;
  logic [9:0] display_height;
  logic restart;
  sbbm_job_t fjob, q0, q1, bjob;
  logic fvalid, fready, bvalid, bready;
  logic [1:0] qcnt;
  logic [5:0] obar;
  logic [9:0] ohgt;
  logic [23:0] ocol;

  assign cfg_ready = 1'b1;
  assign restart = cfg_valid && cfg_index == REG_BIN_COUNT;
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= 9'd32;
      display_height <= 10'd240;
    end else if (cfg_valid) begin
      if (cfg_index == REG_BIN_COUNT) bin_count <= cfg_data[8:0];
      else display_height <= cfg_data;
    end
  end

  sbbm_front #(.BARS(BARS), .MAX_BINS(MAX_BINS)) u_front (
    .clk, .rst, .restart, .bin_count,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .magnitude(s_axis_tdata),
    .job_valid(fvalid), .job_ready(fready), .job(fjob));

  // two entry job queue
  assign fready = qcnt != 2'd2;
  assign bvalid = qcnt != 2'd0;
  assign bjob = q0;
  always_ff @(posedge clk) begin
    if (rst) qcnt <= '0;
    else begin
      priority if (fvalid && fready && bvalid && bready) begin
        if (qcnt == 2'd1) q0 <= fjob;
        else begin q0 <= q1; q1 <= fjob; end
      end else if (fvalid && fready) begin
        if (qcnt == 2'd0) q0 <= fjob; else q1 <= fjob;
        qcnt <= qcnt + 2'd1;
      end else if (bvalid && bready) begin
        q0 <= q1;
        qcnt <= qcnt - 2'd1;
      end
    end
  end

  sbbm_back u_back (
    .clk, .rst, .display_height,
    .job_valid(bvalid), .job_ready(bready), .job(bjob),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_bar(obar), .out_height(ohgt), .out_color(ocol), .out_last(m_axis_tlast));

  assign m_axis_tdata = {1'b0, ocol, ohgt, obar[4:0]};

  a_qcnt: assert property (@(posedge clk) disable iff (rst)
    qcnt <= 2'd2) else $error("queue overflow");
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (obar == 6'(BARS - 1))))
    else $error("last flag mismatch");
  a_bar: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 7'(obar) < 7'(BARS)) else $error("bar index range");
endmodule
`default_nettype wire
